/* hdl/acdf_pkg.sv */
// Shared types, constants and coding functions of the ancillary control-data framer.
`timescale 1ns / 1ps

package acdf_pkg;

   localparam int STATION_BYTES_MAX = 32;
   localparam int STATION_ID_BYTES  = 32;
   localparam int POS_W             = 5;

   localparam int CTRL_BYTES  = 3;
   localparam int DATA_BYTES  = 18;
   localparam int CW_COUNT    = 2 * DATA_BYTES;
   localparam int CW_W        = 7;
   localparam int ZERO_CW     = 2 * (DATA_BYTES - CTRL_BYTES);
   localparam int CODE_BITS   = CW_COUNT * CW_W;
   localparam int OUT_BEATS   = 32;
   localparam int BEAT_W      = $clog2(OUT_BEATS);
   localparam int OFFSET_W    = 6;
   localparam int SKIP_START  = 30;
   localparam int SKIP_LEN    = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_CRC = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_CHAR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_3 = 3'd5;

   localparam logic [7:0] MODE_CHAR_RESET = 8'd83;

   localparam logic [7:0] CH_STX      = 8'h02;
   localparam logic [7:0] CH_ETX      = 8'h03;
   localparam logic [7:0] CH_EOT      = 8'h04;
   localparam logic [7:0] CH_HDR_SVC  = 8'h11;
   localparam logic [7:0] CH_HDR_PROG = 8'h14;
   localparam logic [7:0] CH_HDR_STN  = 8'h16;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_TWO      = 8'h32;

   localparam logic [1:0] SEL_SERVICE = 2'd0;
   localparam logic [1:0] SEL_PROGRAM = 2'd1;
   localparam logic [1:0] SEL_STATION = 2'd2;

   typedef struct packed {
      logic                                scale_crc_present;
      logic [7:0]                          program_mode_char;
      logic [STATION_BYTES_MAX-1:0][7:0]   station;
   } cfg_type;

   typedef struct packed {
      logic [CTRL_BYTES-1:0][7:0] ctrl;
   } frame_entry_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_GEN,
      FS_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      MP_START,
      MP_HDR,
      MP_BODY,
      MP_HASH,
      MP_EOT,
      MP_CK_LO,
      MP_CK_HI,
      MP_ETX
   } msg_phase_type;

   function automatic logic [CW_W-1:0] hamming74(input logic [3:0] nib);
      logic [CW_W-1:0] code;
      case (nib)
         4'h0: code = 7'h00;
         4'h1: code = 7'h07;
         4'h2: code = 7'h19;
         4'h3: code = 7'h1E;
         4'h4: code = 7'h2A;
         4'h5: code = 7'h2D;
         4'h6: code = 7'h33;
         4'h7: code = 7'h34;
         4'h8: code = 7'h4B;
         4'h9: code = 7'h4C;
         4'hA: code = 7'h52;
         4'hB: code = 7'h55;
         4'hC: code = 7'h61;
         4'hD: code = 7'h66;
         4'hE: code = 7'h78;
         default: code = 7'h7F;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] ch;
      if (v < 4'd10) begin
         ch = 8'h30 + {4'h0, v};
      end else begin
         ch = 8'h37 + {4'h0, v};
      end
      return ch;
   endfunction

   function automatic logic [7:0] prog_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h45;
         3'd1: ch = 8'h31;
         3'd2: ch = 8'h43;
         3'd3: ch = 8'h32;
         3'd4: ch = 8'h30;
         default: ch = 8'h41;
      endcase
      return ch;
   endfunction

endpackage

/* hdl/ancillary_control_data_framer.sv */
// Top level of the ancillary control-data framer: registers, front end, queue and emitter.
`timescale 1ns / 1ps

// A frame request with req_frame_request high yields 32 result beats, the OR-mask bytes for
// offsets 0-29 and 34-35, with rsp_last_byte on the last; a request with the bit low yields
// nothing. The emitter sends one beat per cycle while rsp_pop is held, and consecutive frames
// follow without a gap; that single-beat emitter sets the rate. The front end steps the
// control-message sequencer, one control byte per cycle, and then hands the frame to a
// two-frame queue; it takes no new request until that frame is in the queue, and keeps
// accepting while the emitter drains only as long as the queue has room. Register writes are
// taken at any time; station and mode-character writes reach the control messages when the
// next message starts, while the scale-CRC bit is ORed into bit 7 of the third control byte.
module ancillary_control_data_framer
   import acdf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_frame_request,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [OFFSET_W-1:0]    rsp_byte_offset,
   output logic [7:0]             rsp_mask_byte,
   output logic                   rsp_last_byte,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            queue_full;
   logic            queue_push;
   logic            queue_pop;
   logic            queue_valid;
   frame_entry_type push_entry;
   frame_entry_type head_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCALE_CRC: cfg_in.scale_crc_present = csr_data[0];
            CSR_MODE_CHAR: cfg_in.program_mode_char = csr_data[7:0];
            CSR_STATION_0: cfg_in.station[7:0]      = csr_data;
            CSR_STATION_1: cfg_in.station[15:8]     = csr_data;
            CSR_STATION_2: cfg_in.station[23:16]    = csr_data;
            CSR_STATION_3: cfg_in.station[31:24]    = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_crc_present <= 1'b0;
         cfg_ff.program_mode_char <= MODE_CHAR_RESET;
         cfg_ff.station           <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acdf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_push          (req_push),
      .req_frame_request (req_frame_request),
      .req_full          (req_full),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_entry       (push_entry)
   );

   acdf_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (queue_push),
      .wdata (push_entry),
      .full  (queue_full),
      .pop   (queue_pop),
      .valid (queue_valid),
      .rdata (head_entry)
   );

   acdf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_valid     (queue_valid),
      .queue_entry     (head_entry),
      .queue_pop       (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_mask_byte   (rsp_mask_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

/* hdl/acdf_walker.sv */
// Control-message sequencer that yields the next byte of the repeating message cycle.
`timescale 1ns / 1ps

module acdf_walker
   import acdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   output logic [7:0] ctrl_byte
);

   msg_phase_type                       phase_ff, phase_in;
   logic [1:0]                          sel_ff, sel_in;
   logic [POS_W-1:0]                    pos_ff, pos_in;
   logic [7:0]                          ck_ff, ck_in;
   logic [7:0]                          snap_mode_ff, snap_mode_in;
   logic [STATION_BYTES_MAX-1:0][7:0]   snap_station_ff, snap_station_in;
   logic [7:0]                          stn_byte;

   assign stn_byte = snap_station_ff[pos_ff];

   always_comb begin
      case (phase_ff)
         MP_START: ctrl_byte = CH_STX;
         MP_HDR: begin
            if (sel_ff == SEL_SERVICE) begin
               ctrl_byte = CH_HDR_SVC;
            end else if (sel_ff == SEL_PROGRAM) begin
               ctrl_byte = CH_HDR_PROG;
            end else begin
               ctrl_byte = CH_HDR_STN;
            end
         end
         MP_BODY: begin
            if (sel_ff == SEL_PROGRAM) begin
               if (pos_ff < POS_W'(6)) begin
                  ctrl_byte = prog_char(pos_ff[2:0]);
               end else if (pos_ff == POS_W'(6)) begin
                  ctrl_byte = snap_mode_ff;
               end else begin
                  ctrl_byte = CH_TWO;
               end
            end else if (stn_byte == 8'h00) begin
               ctrl_byte = CH_HASH;
            end else begin
               ctrl_byte = stn_byte;
            end
         end
         MP_HASH:  ctrl_byte = CH_HASH;
         MP_EOT:   ctrl_byte = CH_EOT;
         MP_CK_LO: ctrl_byte = hex_digit(ck_ff[3:0]);
         MP_CK_HI: ctrl_byte = hex_digit(ck_ff[7:4]);
         MP_ETX:   ctrl_byte = CH_ETX;
         default:  ctrl_byte = CH_ETX;
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      sel_in          = sel_ff;
      pos_in          = pos_ff;
      ck_in           = ck_ff;
      snap_mode_in    = snap_mode_ff;
      snap_station_in = snap_station_ff;
      if (step) begin
         case (phase_ff)
            MP_START: begin
               snap_mode_in    = cfg.program_mode_char;
               snap_station_in = cfg.station;
               ck_in           = CH_STX;
               phase_in        = MP_HDR;
            end
            MP_HDR: begin
               ck_in  = ck_ff + {1'b0, ctrl_byte[6:0]};
               pos_in = '0;
               if (sel_ff == SEL_SERVICE) begin
                  phase_in = MP_EOT;
               end else begin
                  phase_in = MP_BODY;
               end
            end
            MP_BODY: begin
               ck_in  = ck_ff + {1'b0, ctrl_byte[6:0]};
               pos_in = pos_ff + POS_W'(1);
               if (sel_ff == SEL_PROGRAM) begin
                  if (pos_ff == POS_W'(5) && snap_mode_ff == 8'h00) begin
                     phase_in = MP_CK_LO;
                  end else if (pos_ff == POS_W'(7)) begin
                     phase_in = MP_EOT;
                  end
               end else if (stn_byte == 8'h00) begin
                  phase_in = MP_EOT;
               end else if (pos_ff == POS_W'(STATION_ID_BYTES - 1)) begin
                  phase_in = MP_HASH;
               end
            end
            MP_HASH: begin
               ck_in    = ck_ff + {1'b0, ctrl_byte[6:0]};
               phase_in = MP_EOT;
            end
            MP_EOT: begin
               ck_in    = ck_ff + {1'b0, ctrl_byte[6:0]};
               phase_in = MP_CK_LO;
            end
            MP_CK_LO: phase_in = MP_CK_HI;
            MP_CK_HI: phase_in = MP_ETX;
            MP_ETX: begin
               phase_in = MP_START;
               if (sel_ff == SEL_SERVICE) begin
                  sel_in = SEL_PROGRAM;
               end else if (sel_ff == SEL_PROGRAM) begin
                  sel_in = SEL_STATION;
               end else begin
                  sel_in = SEL_SERVICE;
               end
            end
            default: phase_in = MP_START;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_START;
         sel_ff   <= SEL_SERVICE;
         pos_ff   <= '0;
         ck_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         pos_ff   <= pos_in;
         ck_ff    <= ck_in;
      end
      snap_mode_ff    <= snap_mode_in;
      snap_station_ff <= snap_station_in;
   end

endmodule

/* hdl/acdf_front.sv */
// Request front end: takes frame requests and gathers three control bytes per frame.
`timescale 1ns / 1ps

module acdf_front
   import acdf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_push,
   input  logic            req_frame_request,
   output logic            req_full,
   input  logic            queue_full,
   output logic            queue_push,
   output frame_entry_type queue_entry
);

   front_state_type            state_ff, state_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic [CTRL_BYTES-1:0][7:0] ctrl_ff, ctrl_in;
   logic                       walk_step;
   logic [7:0]                 walk_byte;

   acdf_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (walk_step),
      .ctrl_byte (walk_byte)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (req_push && req_frame_request) begin
               state_in = FS_GEN;
            end
         end
         FS_GEN: begin
            if (cnt_ff == 2'(CTRL_BYTES - 1)) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!queue_full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      req_full   = (state_ff != FS_IDLE);
      walk_step  = (state_ff == FS_GEN);
      queue_push = (state_ff == FS_PUSH) && !queue_full;
   end

   always_comb begin
      cnt_in  = '0;
      ctrl_in = ctrl_ff;
      if (walk_step) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'(CTRL_BYTES - 1)) begin
            ctrl_in[cnt_ff] = walk_byte | {cfg.scale_crc_present, 7'h00};
         end else begin
            ctrl_in[cnt_ff] = walk_byte;
         end
      end
   end

   assign queue_entry.ctrl = ctrl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      ctrl_ff <= ctrl_in;
   end

`ifndef SYNTHESIS
   a_gen_to_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_GEN && cnt_ff == 2'(CTRL_BYTES - 1)) |=> (state_ff == FS_PUSH))
      else $error("front did not hand over a finished frame");
`endif

endmodule

/* hdl/acdf_fifo.sv */
// Short queue of frame entries between the front end and the emitter.
`timescale 1ns / 1ps

module acdf_fifo
   import acdf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  frame_entry_type wdata,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output frame_entry_type rdata
);

   frame_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("frame queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid))
      else $error("frame queue read while empty");
`endif

endmodule

/* hdl/acdf_back.sv */
// Emitter: Hamming codes and interleaves a frame, then sends its 32 mask bytes.
`timescale 1ns / 1ps

module acdf_back
   import acdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_valid,
   input  frame_entry_type     queue_entry,
   output logic                queue_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [OFFSET_W-1:0] rsp_byte_offset,
   output logic [7:0]          rsp_mask_byte,
   output logic                rsp_last_byte
);

   logic [CW_COUNT-1:0][CW_W-1:0] cw;
   logic [OUT_BEATS-1:0][7:0]     mask_ff, mask_in;
   logic [BEAT_W-1:0]             cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          pop_fire;
   logic                          last;

   genvar gi;
   generate
      for (gi = 0; gi < ZERO_CW; gi++) begin : g_zero_cw
         assign cw[gi] = '0;
      end
      for (gi = 0; gi < CTRL_BYTES; gi++) begin : g_ctrl_cw
         assign cw[ZERO_CW + 2 * gi]     = hamming74(queue_entry.ctrl[gi][3:0]);
         assign cw[ZERO_CW + 2 * gi + 1] = hamming74(queue_entry.ctrl[gi][7:4]);
      end
      for (gi = 0; gi < CODE_BITS; gi++) begin : g_interleave
         assign mask_in[gi / 8][7 - (gi % 8)] = cw[gi % CW_COUNT][gi / CW_COUNT];
      end
      for (gi = CODE_BITS; gi < 8 * OUT_BEATS; gi++) begin : g_pad
         assign mask_in[gi / 8][7 - (gi % 8)] = 1'b0;
      end
   endgenerate

   assign last      = (cnt_ff == BEAT_W'(OUT_BEATS - 1));
   assign pop_fire  = rsp_pop && busy_ff;
   assign queue_pop = queue_valid && (!busy_ff || (pop_fire && last));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (queue_pop) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (pop_fire) begin
         if (last) begin
            busy_in = 1'b0;
         end
         cnt_in = cnt_ff + BEAT_W'(1);
      end
   end

   assign rsp_empty     = !busy_ff;
   assign rsp_mask_byte = mask_ff[cnt_ff];
   assign rsp_last_byte = last;

   always_comb begin
      if (cnt_ff < BEAT_W'(SKIP_START)) begin
         rsp_byte_offset = OFFSET_W'(cnt_ff);
      end else begin
         rsp_byte_offset = OFFSET_W'(cnt_ff) + OFFSET_W'(SKIP_LEN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      if (queue_pop) begin
         mask_ff <= mask_in;
      end
   end

`ifndef SYNTHESIS
   a_beat_advance: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && !last) |=> (cnt_ff == $past(cnt_ff) + BEAT_W'(1)))
      else $error("beat counter did not advance on a taken beat");
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && last && !queue_valid) |=> rsp_empty)
      else $error("emitter stayed busy after the last beat with no frame queued");
`endif

endmodule
